### src/blrs_pkg.sv
// ----------------------------------------------------------------------------
// blrs_pkg: shared definitions for the bicolor led matrix row scanner
// Field widths, register indexes, reset defaults, the x pattern, control types.
// ----------------------------------------------------------------------------
package blrs_pkg;

    localparam int DEFAULT_ROWS = 8;
    localparam int MAX_WORDS    = 8;

    localparam int COL_W     = 8;
    localparam int ROWSEL_W  = 3;
    localparam int THR_W     = 8;
    localparam int PERIOD_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // item kind codes
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // rotate mode codes
    localparam logic ROT_ROWS_DOWN  = 1'b0;
    localparam logic ROT_BITS_RIGHT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUALIFY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_MODE       = 2'd2;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0]    THRESHOLD_RST = 8'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 4'd8;
    localparam logic                MODE_RST      = ROT_ROWS_DOWN;

    localparam logic [THR_W-1:0] COUNT_MAX = 8'hFF;

    // x pattern rows by distance from the nearest edge
    localparam logic [COL_W-1:0] X_ROW_EDGE  = 8'h81;
    localparam logic [COL_W-1:0] X_ROW_NEXT  = 8'h42;
    localparam logic [COL_W-1:0] X_ROW_INNER = 8'h24;
    localparam logic [COL_W-1:0] X_ROW_MID   = 8'h18;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    // one operation on a plane store per cycle
    typedef struct packed
    {
        logic                wr_en;
        logic [ROWSEL_W-1:0] row;
        logic [COL_W-1:0]    data;
        logic                load_x;
        logic                rot_down;
        logic                rot_bits;
        logic                shift;
    } plane_ctl_t;

    function automatic logic [COL_W-1:0] x_row(input int idx, input int rows);
        int d;
        int e;
        logic [COL_W-1:0] r;
        d = idx;
        e = rows - 1 - idx;
        if (e < d)
            d = e;
        case (d)
            0:       r = X_ROW_EDGE;
            1:       r = X_ROW_NEXT;
            2:       r = X_ROW_INNER;
            default: r = X_ROW_MID;
        endcase
        return r;
    endfunction

endpackage

### src/blrs_if.sv
// ----------------------------------------------------------------------------
// blrs_if: channel interfaces of the row scanner
// Input item, row word result and configuration write channels.
// ----------------------------------------------------------------------------
interface blrs_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [blrs_pkg::ROWSEL_W-1:0]   row_number;
    logic [blrs_pkg::COL_W-1:0]      red_byte;
    logic [blrs_pkg::COL_W-1:0]      green_byte;
    logic                            alarm_red_pin;
    logic                            alarm_green_pin;

    modport source (output valid, kind, row_number, red_byte, green_byte,
                    alarm_red_pin, alarm_green_pin, input ready);
    modport sink (input valid, kind, row_number, red_byte, green_byte,
                  alarm_red_pin, alarm_green_pin, output ready);
endinterface

interface blrs_out_if;
    logic                            valid;
    logic                            ready;
    logic [blrs_pkg::ROWSEL_W-1:0]   row_select;
    logic [blrs_pkg::COL_W-1:0]      red_bits;
    logic [blrs_pkg::COL_W-1:0]      green_bits;
    logic                            alarm_active;
    logic                            last_row;

    modport source (output valid, row_select, red_bits, green_bits, alarm_active,
                    last_row, input ready);
    modport sink (input valid, row_select, red_bits, green_bits, alarm_active,
                  last_row, output ready);
endinterface

interface blrs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [blrs_pkg::CFG_IDX_W-1:0]   index;
    logic [blrs_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/blrs_plane.sv
// ----------------------------------------------------------------------------
// blrs_plane: one color plane as a circular row shift register
// Row write, x load, rotate down, rotate bits, and a scan shift toward row 0.
// ----------------------------------------------------------------------------
module blrs_plane #(
    parameter int ROWS = blrs_pkg::DEFAULT_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  blrs_pkg::plane_ctl_t          ctl,
    output logic [blrs_pkg::COL_W-1:0]    head
);

    logic [blrs_pkg::COL_W-1:0] plane_reg [ROWS];
    logic                       wr_in_range;

    // rows past the store are dropped
    assign wr_in_range = (32'(ctl.row) < ROWS);
    assign head        = plane_reg[0];

    for (genvar i = 0; i < ROWS; i++)
    begin : g_row
        localparam int NXT = (i == ROWS - 1) ? 0 : i + 1;
        localparam int PRV = (i == 0) ? ROWS - 1 : i - 1;
        localparam logic [blrs_pkg::COL_W-1:0] XR = blrs_pkg::x_row(i, ROWS);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg[i] <= '0;
            end
            else if (ctl.load_x)
            begin
                plane_reg[i] <= XR;
            end
            else if (ctl.rot_down)
            begin
                plane_reg[i] <= plane_reg[PRV];
            end
            else if (ctl.rot_bits)
            begin
                plane_reg[i] <= {plane_reg[i][0], plane_reg[i][blrs_pkg::COL_W-1:1]};
            end
            else if (ctl.shift)
            begin
                plane_reg[i] <= plane_reg[NXT];
            end
            else if (ctl.wr_en && wr_in_range && (32'(ctl.row) == i))
            begin
                plane_reg[i] <= ctl.data;
            end
        end
    end

endmodule

### src/bicolor_led_matrix_row_scanner_unit.sv
// ----------------------------------------------------------------------------
// bicolor_led_matrix_row_scanner_unit: 8 column red/green matrix row scanner
// Holds both planes, qualifies the alarm pins and emits masked row words.
// ----------------------------------------------------------------------------
// write item: written into both planes when accepted, no result
// frame item: first row word registered in the scan state after the accept, then
//   one word per cycle while the output takes them; the input stays blocked until
//   the row shift register has circulated each plane once past its head
// output backpressure stalls the scan; the next item may enter while the last word waits
// reset clears both planes, the pass counter, alarm flag and divider, loads register defaults
module bicolor_led_matrix_row_scanner_unit #(
    parameter int ROWS = blrs_pkg::DEFAULT_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    blrs_in_if.sink    in_ch,
    blrs_out_if.source out_ch,
    blrs_cfg_if.sink   cfg
);

    localparam int ROW_W = $clog2(ROWS);
    // words per frame, capped by the 3 bit row select
    localparam int WORDS = (ROWS < blrs_pkg::MAX_WORDS) ? ROWS : blrs_pkg::MAX_WORDS;

    // control state
    blrs_pkg::scan_state_t           state_reg, state_next;
    logic [ROW_W-1:0]                cnt_reg, cnt_next;
    logic [blrs_pkg::THR_W-1:0]      count_reg, count_next;
    logic                            flag_reg, flag_next;
    logic [blrs_pkg::PERIOD_W-1:0]   div_reg, div_next;

    // configuration
    logic [blrs_pkg::THR_W-1:0]      thr_reg;
    logic [blrs_pkg::PERIOD_W-1:0]   period_reg;
    logic                            mode_reg;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [blrs_pkg::ROWSEL_W-1:0]   row_sel_reg, row_sel_next;
    logic [blrs_pkg::COL_W-1:0]      red_out_reg, red_out_next;
    logic [blrs_pkg::COL_W-1:0]      green_out_reg, green_out_next;
    logic                            alarm_out_reg, alarm_out_next;
    logic                            last_out_reg, last_out_next;

    blrs_pkg::plane_ctl_t            red_ctl, green_ctl;
    logic [blrs_pkg::COL_W-1:0]      red_head, green_head;

    logic                            in_acc;
    logic                            frame_acc;
    logic                            write_acc;
    logic                            any_pin;
    logic                            new_flag;
    logic [blrs_pkg::PERIOD_W:0]     div_inc;
    logic                            div_wrap;
    logic                            step;
    logic                            emit;

    // ------------------------------------------------------------------ planes
    blrs_plane #(.ROWS(ROWS)) u_red
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (red_ctl),
        .head  (red_head)
    );

    blrs_plane #(.ROWS(ROWS)) u_green
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (green_ctl),
        .head  (green_head)
    );

    // ---------------------------------------------------------- configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= blrs_pkg::THRESHOLD_RST;
            period_reg <= blrs_pkg::PERIOD_RST;
            mode_reg   <= blrs_pkg::MODE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                blrs_pkg::CFG_QUALIFY_THRESHOLD: thr_reg    <= cfg.data;
                blrs_pkg::CFG_ROTATE_PERIOD:     period_reg <= cfg.data[blrs_pkg::PERIOD_W-1:0];
                blrs_pkg::CFG_ROTATE_MODE:       mode_reg   <= cfg.data[0];
                default:                         ;  // unused index, beat dropped
            endcase
        end
    end

    // ------------------------------------------------------------- item entry
    // a new item enters only while no frame is being scanned
    assign in_ch.ready = (state_reg == blrs_pkg::ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign frame_acc   = in_acc && (in_ch.kind == blrs_pkg::KIND_FRAME);
    assign write_acc   = in_acc && (in_ch.kind == blrs_pkg::KIND_WRITE);

    // alarm qualification: the flag latches once the old count passes the threshold
    assign any_pin  = in_ch.alarm_red_pin || in_ch.alarm_green_pin;
    assign new_flag = any_pin && (flag_reg || (count_reg > thr_reg));

    // rotation divider, compared one bit wider so a count of 15 never wraps
    assign div_inc  = {1'b0, div_reg} + 1'b1;
    assign div_wrap = (div_inc > {1'b0, period_reg});

    // ------------------------------------------------------------------- scan
    // each step moves both planes one row toward the head; after ROWS steps
    // they are back in place, the first WORDS heads go out as row words
    assign step = (state_reg == blrs_pkg::ST_SCAN)
                  && ((32'(cnt_reg) >= WORDS) || !out_valid_reg || out_ch.ready);
    assign emit = step && (32'(cnt_reg) < WORDS);

    always_comb
    begin
        red_ctl          = '0;
        red_ctl.wr_en    = write_acc;
        red_ctl.row      = in_ch.row_number;
        red_ctl.data     = in_ch.red_byte;
        red_ctl.load_x   = frame_acc && new_flag;
        red_ctl.shift    = step;

        green_ctl          = '0;
        green_ctl.wr_en    = write_acc;
        green_ctl.row      = in_ch.row_number;
        green_ctl.data     = in_ch.green_byte;
        green_ctl.rot_down = frame_acc && !new_flag && div_wrap
                             && (mode_reg == blrs_pkg::ROT_ROWS_DOWN);
        green_ctl.rot_bits = frame_acc && !new_flag && div_wrap
                             && (mode_reg == blrs_pkg::ROT_BITS_RIGHT);
        green_ctl.shift    = step;
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        div_next       = div_reg;
        out_valid_next = out_valid_reg;
        row_sel_next   = row_sel_reg;
        red_out_next   = red_out_reg;
        green_out_next = green_out_reg;
        alarm_out_next = alarm_out_reg;
        last_out_next  = last_out_reg;

        // output slot drains when taken, refills on emit below
        if (out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            blrs_pkg::ST_IDLE:
            begin
                if (frame_acc)
                begin
                    // saturating pass counter, cleared with the flag when both pins are low
                    if (any_pin)
                    begin
                        if (count_reg != blrs_pkg::COUNT_MAX)
                            count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = '0;
                    end
                    flag_next = new_flag;

                    // divider only runs while green is shown
                    if (!new_flag)
                        div_next = div_wrap ? '0 : div_inc[blrs_pkg::PERIOD_W-1:0];

                    cnt_next   = '0;
                    state_next = blrs_pkg::ST_SCAN;
                end
            end

            blrs_pkg::ST_SCAN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    row_sel_next   = blrs_pkg::ROWSEL_W'(cnt_reg);
                    red_out_next   = flag_reg ? red_head : '0;
                    green_out_next = flag_reg ? '0 : green_head;
                    alarm_out_next = flag_reg;
                    last_out_next  = (32'(cnt_reg) == WORDS - 1);
                end
                if (step)
                begin
                    if (32'(cnt_reg) == ROWS - 1)
                        state_next = blrs_pkg::ST_IDLE;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = blrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blrs_pkg::ST_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            div_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            div_reg       <= div_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // row word payload, no reset needed
    always_ff @(posedge clk)
    begin
        row_sel_reg   <= row_sel_next;
        red_out_reg   <= red_out_next;
        green_out_reg <= green_out_next;
        alarm_out_reg <= alarm_out_next;
        last_out_reg  <= last_out_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.row_select   = row_sel_reg;
    assign out_ch.red_bits     = red_out_reg;
    assign out_ch.green_bits   = green_out_reg;
    assign out_ch.alarm_active = alarm_out_reg;
    assign out_ch.last_row     = last_out_reg;

    // ------------------------------------------------------------- assertions
    // a row word only appears out of a scan
    a_word_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == blrs_pkg::ST_SCAN))
        else $error("row word raised outside a scan");

    // red and green are never shown together
    a_one_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && alarm_out_reg |-> (green_out_reg == '0))
        else $error("green shown while alarm active");

    // a latched alarm implies at least one qualifying pass
    a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> (count_reg != '0))
        else $error("alarm flag set with zero pass count");

    // scan counter stays inside the plane
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == blrs_pkg::ST_SCAN) |-> (32'(cnt_reg) < ROWS))
        else $error("scan counter past last row");

    // after the final word of a frame the next word starts a new frame
    a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ch.ready && last_out_reg
            |=> (!out_valid_reg || (row_sel_reg == '0)))
        else $error("row word after last row is not row zero");

endmodule

### tb/bicolor_led_matrix_row_scanner_unit_test.sv
// ----------------------------------------------------------------------------
// bicolor_led_matrix_row_scanner_unit_test: self-checking bench for the scanner
// Sends row writes and frame passes, keeps its own copy of both planes, the
// alarm qualifier and the rotation divider, and checks every row word it gets.
// ----------------------------------------------------------------------------
module bicolor_led_matrix_row_scanner_unit_test;
    import blrs_pkg::*;

    localparam int ROWS          = DEFAULT_ROWS;
    localparam int WORDS         = (ROWS < MAX_WORDS) ? ROWS : MAX_WORDS;
    // a frame holds the input until its scan is done, give the tail some slack
    localparam int SETTLE_CYCLES = ROWS + 6;
    localparam int CYCLE_LIMIT   = 600000;

    // one input beat
    typedef struct packed
    {
        logic                kind;
        logic [ROWSEL_W-1:0] row_number;
        logic [COL_W-1:0]    red_byte;
        logic [COL_W-1:0]    green_byte;
        logic                alarm_red_pin;
        logic                alarm_green_pin;
    } scan_item_t;

    // one row word beat
    typedef struct packed
    {
        logic [ROWSEL_W-1:0] row_select;
        logic [COL_W-1:0]    red_bits;
        logic [COL_W-1:0]    green_bits;
        logic                alarm_active;
        logic                last_row;
    } row_word_t;

    localparam int ITEM_W = $bits(scan_item_t);

    logic clk = 1'b0;
    logic rst_n;

    blrs_in_if  in_ch ();
    blrs_out_if out_ch ();
    blrs_cfg_if cfg_ch ();

    bicolor_led_matrix_row_scanner_unit #(
        .ROWS (ROWS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // scanner copy: planes, qualifier, divider and register values
    // ------------------------------------------------------------------------
    logic [COL_W-1:0]    red_rows   [ROWS];
    logic [COL_W-1:0]    green_rows [ROWS];
    logic [THR_W-1:0]    pass_count;
    logic                alarm_on;
    logic [PERIOD_W-1:0] rotate_div;
    logic [THR_W-1:0]    threshold_cfg;
    logic [PERIOD_W-1:0] period_cfg;
    logic                mode_cfg;

    // row words still owed by the block, oldest first
    row_word_t row_words_due[$];

    int error_count  = 0;
    int cycle_count  = 0;
    int items_taken  = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_request = 0;
    int hold_left    = 0;

    function void clear_scanner_copy();
        for (int i = 0; i < ROWS; i++)
        begin
            red_rows[i]   = '0;
            green_rows[i] = '0;
        end
        pass_count    = '0;
        alarm_on      = 1'b0;
        rotate_div    = '0;
        threshold_cfg = THRESHOLD_RST;
        period_cfg    = PERIOD_RST;
        mode_cfg      = MODE_RST;
    endfunction

    // x pattern row: distance to the nearer edge, capped at the middle pair
    function automatic logic [COL_W-1:0] x_row_bits(int i);
        int row_gap;
        row_gap = (ROWS - 1 - i < i) ? ROWS - 1 - i : i;
        case (row_gap)
            0:       return X_ROW_EDGE;
            1:       return X_ROW_NEXT;
            2:       return X_ROW_INNER;
            default: return X_ROW_MID;
        endcase
    endfunction

    function void turn_green();
        logic [COL_W-1:0] wrap;
        if (mode_cfg == ROT_BITS_RIGHT)
        begin
            // bit 0 wraps round to bit 7
            for (int i = 0; i < ROWS; i++)
                green_rows[i] = {green_rows[i][0], green_rows[i][COL_W-1:1]};
        end
        else
        begin
            // last row wraps round to row 0
            wrap = green_rows[ROWS-1];
            for (int i = ROWS - 1; i > 0; i--)
                green_rows[i] = green_rows[i-1];
            green_rows[0] = wrap;
        end
    endfunction

    // one frame pass: qualify the pins, update the planes, owe the row words
    function void predict_frame(scan_item_t it);
        row_word_t word;
        int        next_div;
        if (it.alarm_red_pin || it.alarm_green_pin)
        begin
            // the count held before this pass decides
            if (pass_count > threshold_cfg)
                alarm_on = 1'b1;
            if (pass_count != COUNT_MAX)
                pass_count = pass_count + 1'b1;
        end
        else
        begin
            pass_count = '0;
            alarm_on   = 1'b0;
        end

        if (alarm_on)
        begin
            for (int i = 0; i < ROWS; i++)
                red_rows[i] = x_row_bits(i);
        end
        else
        begin
            // divider increments without wrap before the compare
            next_div = int'(rotate_div) + 1;
            if (next_div > int'(period_cfg))
            begin
                rotate_div = '0;
                turn_green();
            end
            else
                rotate_div = PERIOD_W'(next_div);
        end

        for (int j = 0; j < WORDS; j++)
        begin
            word.row_select   = ROWSEL_W'(j);
            word.red_bits     = alarm_on ? red_rows[j] : '0;
            word.green_bits   = alarm_on ? '0 : green_rows[j];
            word.alarm_active = alarm_on;
            word.last_row     = (j == WORDS - 1);
            row_words_due.push_back(word);
        end
    endfunction

    function void take_item(scan_item_t it);
        if (it.kind == KIND_WRITE)
        begin
            // rows past the plane depth are dropped
            if (int'(it.row_number) < ROWS)
            begin
                red_rows[it.row_number]   = it.red_byte;
                green_rows[it.row_number] = it.green_byte;
            end
        end
        else
            predict_frame(it);
    endfunction

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic scan_item_t make_write(logic [ROWSEL_W-1:0] row,
                                              logic [COL_W-1:0] red,
                                              logic [COL_W-1:0] green);
        scan_item_t it;
        it.kind            = KIND_WRITE;
        it.row_number      = row;
        it.red_byte        = red;
        it.green_byte      = green;
        it.alarm_red_pin   = 1'($urandom_range(1));
        it.alarm_green_pin = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic scan_item_t random_write();
        return make_write(ROWSEL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
    endfunction

    // row and data fields of a frame beat carry junk, the block ignores them
    function automatic scan_item_t make_frame(logic red_pin, logic green_pin);
        scan_item_t it;
        it.kind            = KIND_FRAME;
        it.row_number      = ROWSEL_W'($urandom);
        it.red_byte        = COL_W'($urandom);
        it.green_byte      = COL_W'($urandom);
        it.alarm_red_pin   = red_pin;
        it.alarm_green_pin = green_pin;
        return it;
    endfunction

    function automatic scan_item_t alarm_frame();
        logic [1:0] pins;
        pins = 2'($urandom_range(3, 1));
        return make_frame(pins[0], pins[1]);
    endfunction

    // ------------------------------------------------------------------------
    // mismatch reporting and the row word checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_words
        row_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (row_words_due.size() == 0)
                report_mismatch($sformatf("row word with nothing owed, row %0d",
                                          out_ch.row_select));
            else
            begin
                want = row_words_due.pop_front();
                if (out_ch.row_select !== want.row_select)
                    report_mismatch($sformatf("row_select got %0d want %0d",
                                              out_ch.row_select, want.row_select));
                if (out_ch.red_bits !== want.red_bits)
                    report_mismatch($sformatf("row %0d red_bits got %h want %h",
                                              want.row_select, out_ch.red_bits,
                                              want.red_bits));
                if (out_ch.green_bits !== want.green_bits)
                    report_mismatch($sformatf("row %0d green_bits got %h want %h",
                                              want.row_select, out_ch.green_bits,
                                              want.green_bits));
                if (out_ch.alarm_active !== want.alarm_active)
                    report_mismatch($sformatf("row %0d alarm_active got %b want %b",
                                              want.row_select, out_ch.alarm_active,
                                              want.alarm_active));
                if (out_ch.last_row !== want.last_row)
                    report_mismatch($sformatf("row %0d last_row got %b want %b",
                                              want.row_select, out_ch.last_row,
                                              want.last_row));
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL bicolor_led_matrix_row_scanner_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------
    // valid stays high between back-to-back beats, it only drops for a gap
    task automatic send_item(scan_item_t it);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.kind            <= it.kind;
        in_ch.row_number      <= it.row_number;
        in_ch.red_byte        <= it.red_byte;
        in_ch.green_byte      <= it.green_byte;
        in_ch.alarm_red_pin   <= it.alarm_red_pin;
        in_ch.alarm_green_pin <= it.alarm_green_pin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        take_item(it);
        items_taken++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_QUALIFY_THRESHOLD: threshold_cfg = val;
            CFG_ROTATE_PERIOD:     period_cfg    = val[PERIOD_W-1:0];
            CFG_ROTATE_MODE:       mode_cfg      = val[0];
            default:               ;
        endcase
    endtask

    // only called with the block idle
    task automatic set_config(logic [THR_W-1:0] thr, logic [PERIOD_W-1:0] period,
                              logic mode);
        write_reg(CFG_QUALIFY_THRESHOLD, thr);
        write_reg(CFG_ROTATE_PERIOD, CFG_DAT_W'(period));
        write_reg(CFG_ROTATE_MODE, CFG_DAT_W'(mode));
        cfg_ch.valid <= 1'b0;
    endtask

    // sender pauses until every owed word is in, then lets the scan wind down
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (row_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // reset registers and cleared planes first
        send_item(make_frame(1'b0, 1'b0));
        wait_idle();

        // row shift every pass, extremes of row and data
        set_config(THRESHOLD_RST, 4'd0, ROT_ROWS_DOWN);
        send_item(make_write(3'd0, 8'hFF, 8'h00));
        send_item(make_write(3'd7, 8'h00, 8'hFF));
        send_item(make_write(3'd3, 8'hA5, 8'h5A));
        send_item(make_frame(1'b0, 1'b0));
        send_item(make_frame(1'b1, 1'b0));
        send_item(make_frame(1'b0, 1'b1));
        wait_idle();

        // bit rotation, alarm qualifies on the second pass at threshold zero
        set_config(8'd0, 4'd0, ROT_BITS_RIGHT);
        send_item(make_write(3'd5, 8'h7E, 8'h81));
        send_item(make_frame(1'b0, 1'b0));
        send_item(make_frame(1'b1, 1'b1));
        send_item(make_frame(1'b1, 1'b1));
        send_item(make_frame(1'b0, 1'b1));
        // a written red row is overwritten by the x on the next alarm pass
        send_item(make_write(3'd0, 8'h00, 8'hFF));
        send_item(make_frame(1'b1, 1'b0));
        // both pins low drops the alarm, green comes back
        send_item(make_frame(1'b0, 1'b0));
        wait_idle();
    endtask

    // raising the threshold while the alarm is held keeps the flag
    task automatic test_threshold_raise();
        set_config(8'd0, PERIOD_RST, ROT_ROWS_DOWN);
        repeat (3) send_item(make_frame(1'b1, 1'b0));
        wait_idle();
        set_config(8'd200, PERIOD_RST, ROT_ROWS_DOWN);
        repeat (2) send_item(make_frame(1'b0, 1'b1));
        send_item(make_frame(1'b0, 1'b0));
        repeat (4) send_item(make_frame(1'b1, 1'b1));
        wait_idle();
    endtask

    // threshold one below the maximum: only a saturated count can qualify
    task automatic test_count_saturation();
        set_config(8'd254, 4'd15, ROT_BITS_RIGHT);
        repeat (258) send_item(alarm_frame());
        wait_idle();
    endtask

    // receiver holds off while frames keep coming, input has to back up
    task automatic test_output_hold();
        set_config(8'd3, 4'd2, ROT_ROWS_DOWN);
        hold_request = 300;
        repeat (16)
        begin
            if ($urandom_range(3) == 0)
                send_item(make_frame(1'b0, 1'b0));
            else
                send_item(alarm_frame());
        end
        wait_idle();
    endtask

    // well-formed alarm runs, write bursts and quiet passes, a little noise
    task automatic run_random(int n);
        int stop_at;
        int run_len;
        int pick;
        logic [ITEM_W-1:0] raw;
        stop_at = items_taken + n;
        while (items_taken < stop_at)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                repeat ($urandom_range(4, 1))
                    send_item(random_write());
            else if (pick < 7)
            begin
                // random length up to the threshold plus four, capped at 24
                run_len = $urandom_range(int'(threshold_cfg) + 4, 1);
                if (run_len > 24)
                    run_len = 24;
                repeat (run_len)
                begin
                    if ($urandom_range(7) == 0)
                        send_item(random_write());
                    send_item(alarm_frame());
                end
            end
            else if (pick < 9)
                repeat ($urandom_range(3, 1))
                    send_item(make_frame(1'b0, 1'b0));
            else
            begin
                raw = ITEM_W'($urandom);
                send_item(scan_item_t'(raw));
            end
        end
    endtask

    task automatic test_random_phases();
        // no idling on either side
        set_config(THR_W'($urandom_range(12)), 4'd0, ROT_ROWS_DOWN);
        run_random(30);
        wait_idle();

        // sender gaps
        src_idle_pct = 53;
        set_config(THR_W'($urandom_range(12)), 4'd15, ROT_BITS_RIGHT);
        run_random(30);
        wait_idle();

        // receiver stalls
        src_idle_pct   = 0;
        sink_stall_pct = 53;
        set_config(THR_W'($urandom_range(12)), PERIOD_W'($urandom_range(15)),
                   ROT_ROWS_DOWN);
        run_random(30);
        wait_idle();

        // light idling on both sides
        src_idle_pct   = 8;
        sink_stall_pct = 8;
        set_config(THR_W'($urandom_range(12)), PERIOD_W'($urandom_range(15)),
                   ROT_BITS_RIGHT);
        run_random(30);
        wait_idle();

        // no idling again, alarm qualifies only on a saturated count here
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_config(8'd254, PERIOD_W'($urandom_range(15)), 1'($urandom_range(1)));
        run_random(30);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.kind            <= KIND_WRITE;
        in_ch.row_number      <= '0;
        in_ch.red_byte        <= '0;
        in_ch.green_byte      <= '0;
        in_ch.alarm_red_pin   <= 1'b0;
        in_ch.alarm_green_pin <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= CFG_QUALIFY_THRESHOLD;
        cfg_ch.data           <= '0;
        clear_scanner_copy();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_threshold_raise();
        test_count_saturation();
        test_output_hold();
        test_random_phases();

        if (row_words_due.size() != 0)
            report_mismatch($sformatf("%0d row words never arrived",
                                      row_words_due.size()));
        if (error_count == 0)
            $display("PASS bicolor_led_matrix_row_scanner_unit");
        else
            $display("FAIL bicolor_led_matrix_row_scanner_unit");
        $finish;
    end

endmodule

### sim.f
src/blrs_pkg.sv
src/blrs_if.sv
src/blrs_plane.sv
src/bicolor_led_matrix_row_scanner_unit.sv
tb/bicolor_led_matrix_row_scanner_unit_test.sv
